// ===== rtl/dct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dct_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_OUT_W  = 20;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned FRAC_BITS   = 5;
  // rom coefficient: magnitude up to the dc gain of a 4-point block (16)
  localparam int unsigned COEF_W      = 6;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;
  localparam int unsigned STEP_W      = 9;
  localparam int          COEF_MAX    = 524287;
  localparam int          COEF_MIN    = -524288;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr;  // start a new coefficient sum
    logic vld;  // operand pair valid this cycle
  } mac_ctl_t;

  typedef struct packed {
    logic load; // restart phase for a new frequency index
    logic adv;  // step to the next sample position
  } gen_ctl_t;

  // floor(2^FRAC_BITS / sqrt(len)), worked out at elaboration
  function automatic int dc_gain(input int len);
    int g;
    g = 0;
    for (int j = 1; j <= (1 << FRAC_BITS); j++) begin
      if (j * j * len <= (1 << (2 * FRAC_BITS))) begin
        g = j;
      end
    end
    return g;
  endfunction

  // quarter-wave cosine magnitude, steps of pi/128
  function automatic logic [2:0] quarter_mag(input logic [STEP_W-1:0] step);
    logic [2:0] m;
    if (step < STEP_W'(20)) begin
      m = 3'd5;
    end else if (step <= STEP_W'(32)) begin
      m = 3'd4;
    end else if (step <= STEP_W'(41)) begin
      m = 3'd3;
    end else if (step <= STEP_W'(49)) begin
      m = 3'd2;
    end else if (step <= STEP_W'(56)) begin
      m = 3'd1;
    end else begin
      m = 3'd0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dct_ii_block_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel      | dir | handshake                                   | payload
// sample       | in  | sample_valid_i / sample_ready_o             | sample_i
// coefficient  | out | coefficient_valid_o / coefficient_ready_i   | coefficient_o,
//              |     |                                             | coefficient_index_o,
//              |     |                                             | last_of_block_o
//
// samples are taken one per cycle until the block holds BLOCK_LENGTH of them.
// each coefficient then takes its turn on the one shared multiply-accumulate
// (buffer read, multiply, accumulate, drain, emit). sample_ready_o is low
// while coefficients are computed; a stalled output beat holds the next
// coefficient in the emit step. reset clears the fill count and control
// only; the sample buffer is written before it is read.

module dct_ii_block_transform #(
  parameter int unsigned BLOCK_LENGTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [dct_pkg::SAMPLE_W-1:0]            sample_i,
  input  wire logic                                    sample_valid_i,
  output logic                                         sample_ready_o,
  output logic [dct_pkg::COEF_OUT_W-1:0]               coefficient_o,
  output logic [dct_pkg::IDX_W-1:0]                    coefficient_index_o,
  output logic                                         last_of_block_o,
  output logic                                         coefficient_valid_o,
  input  wire logic                                    coefficient_ready_i
);

  localparam int unsigned KW    = $clog2(BLOCK_LENGTH);
  localparam int unsigned ACC_W = dct_pkg::PROD_W + KW;
  localparam logic [KW-1:0] LAST_POS = KW'(BLOCK_LENGTH - 1);

  dct_pkg::state_e state_q, state_d;
  logic [KW-1:0] fill_q, fill_d;
  logic [KW-1:0] n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic          rd_vld_q;
  logic [dct_pkg::SAMPLE_W-1:0] rd_q;
  logic [dct_pkg::SAMPLE_W-1:0] buf_mem [BLOCK_LENGTH];

  logic          in_beat;
  logic          issue;
  logic          emit;
  logic          out_vld_q, out_vld_d;
  logic [dct_pkg::COEF_OUT_W-1:0] coef_q;
  logic [dct_pkg::IDX_W-1:0]      idx_q;
  logic          last_q;
  logic [KW+dct_pkg::IDX_W-1:0]   k_ext;

  logic [KW-1:0] gen_k;
  dct_pkg::gen_ctl_t gen_ctl;
  dct_pkg::mac_ctl_t mac_ctl;
  logic signed [dct_pkg::COEF_W-1:0]     rom_coef;
  logic signed [dct_pkg::COEF_OUT_W-1:0] mac_result;
  logic          mac_busy;

  assign in_beat = sample_valid_i && sample_ready_o;

  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    n_d            = n_q;
    k_d            = k_q;
    sample_ready_o = 1'b0;
    issue          = 1'b0;
    emit           = 1'b0;
    gen_k          = '0;
    gen_ctl        = '0;
    mac_ctl.clr    = 1'b0;
    mac_ctl.vld    = rd_vld_q;
    unique case (state_q)
      dct_pkg::ST_COLLECT: begin
        sample_ready_o = 1'b1;
        if (in_beat) begin
          if (fill_q == LAST_POS) begin
            fill_d       = '0;
            k_d          = '0;
            n_d          = '0;
            gen_ctl.load = 1'b1;
            mac_ctl.clr  = 1'b1;
            state_d      = dct_pkg::ST_MAC;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      dct_pkg::ST_MAC: begin
        issue       = 1'b1;
        gen_ctl.adv = 1'b1;
        if (n_q == LAST_POS) begin
          n_d     = '0;
          state_d = dct_pkg::ST_DRAIN;
        end else begin
          n_d = n_q + 1'b1;
        end
      end
      dct_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = dct_pkg::ST_EMIT;
        end
      end
      dct_pkg::ST_EMIT: begin
        if (!out_vld_q || coefficient_ready_i) begin
          emit = 1'b1;
          if (k_q == LAST_POS) begin
            state_d = dct_pkg::ST_COLLECT;
          end else begin
            k_d          = k_q + 1'b1;
            gen_k        = k_q + 1'b1;
            gen_ctl.load = 1'b1;
            mac_ctl.clr  = 1'b1;
            state_d      = dct_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_d = dct_pkg::ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (coefficient_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dct_pkg::ST_COLLECT;
      fill_q    <= '0;
      n_q       <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      n_q       <= n_d;
      k_q       <= k_d;
      rd_vld_q  <= issue;
      out_vld_q <= out_vld_d;
    end
  end

  // sample buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      buf_mem[fill_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= buf_mem[n_q];
    end
  end

  assign k_ext = {{dct_pkg::IDX_W{1'b0}}, k_q};

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coef_q <= mac_result;
      idx_q  <= k_ext[dct_pkg::IDX_W-1:0];
      last_q <= (k_q == LAST_POS);
    end
  end

  assign coefficient_o       = coef_q;
  assign coefficient_index_o = idx_q;
  assign last_of_block_o     = last_q;
  assign coefficient_valid_o = out_vld_q;

  dct_coef_gen #(
    .BLOCK_LENGTH(BLOCK_LENGTH)
  ) u_coef_gen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (gen_ctl),
    .k_i   (gen_k),
    .coef_o(rom_coef)
  );

  dct_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .sample_i($signed(rd_q)),
    .coef_i  (rom_coef),
    .busy_o  (mac_busy),
    .result_o(mac_result)
  );

  // a coefficient beat only starts out of the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(coefficient_valid_o) |-> $past(state_q == dct_pkg::ST_EMIT))
    else $error("coefficient beat started outside emit");

  // the sum is final before it is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dct_pkg::ST_EMIT) |-> (!rd_vld_q && !mac_busy))
    else $error("emit with products still in flight");

  // the fill count restarts at each block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dct_pkg::ST_MAC) |-> (fill_q == '0))
    else $error("fill count not cleared during transform");

endmodule

`default_nettype wire

// ===== rtl/dct_coef_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dct_coef_gen #(
  parameter int unsigned BLOCK_LENGTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire dct_pkg::gen_ctl_t                       ctl_i,
  input  wire logic [$clog2(BLOCK_LENGTH)-1:0]         k_i,
  output logic signed [dct_pkg::COEF_W-1:0]            coef_o
);

  localparam int unsigned PW  = $clog2(4 * BLOCK_LENGTH);
  localparam int          DC  = dct_pkg::dc_gain(BLOCK_LENGTH);
  localparam logic [PW-1:0] Q1 = PW'(BLOCK_LENGTH);
  localparam logic [PW-1:0] Q2 = PW'(2 * BLOCK_LENGTH);
  localparam logic [PW-1:0] Q3 = PW'(3 * BLOCK_LENGTH);
  localparam logic [PW:0]   Q4 = (PW + 1)'(4 * BLOCK_LENGTH);

  logic [PW-1:0] phase_q, phase_d;
  logic [PW-1:0] twok_q, twok_d;
  logic          dc_q, dc_d;
  logic [PW:0]   phase_sum;
  logic [PW-1:0] step;
  logic          neg;
  logic [PW+dct_pkg::STEP_W-1:0] step_ext;
  logic [2:0]    mag;
  logic signed [dct_pkg::COEF_W-1:0] coef_d;

  // phase of sample n for index k is (2n+1)k mod 4L, stepped by 2k
  assign phase_sum = {1'b0, phase_q} + {1'b0, twok_q};

  always_comb begin
    phase_d = phase_q;
    twok_d  = twok_q;
    dc_d    = dc_q;
    if (ctl_i.load) begin
      phase_d = PW'(k_i);
      twok_d  = PW'({k_i, 1'b0});
      dc_d    = (k_i == '0);
    end else if (ctl_i.adv) begin
      if (phase_sum >= Q4) begin
        phase_d = PW'(phase_sum - Q4);
      end else begin
        phase_d = phase_sum[PW-1:0];
      end
    end
  end

  // fold the phase into one quarter wave
  always_comb begin
    if (phase_q <= Q1) begin
      step = phase_q;
      neg  = 1'b0;
    end else if (phase_q <= Q2) begin
      step = Q2 - phase_q;
      neg  = 1'b1;
    end else if (phase_q <= Q3) begin
      step = phase_q - Q2;
      neg  = 1'b1;
    end else begin
      step = PW'(Q4 - {1'b0, phase_q});
      neg  = 1'b0;
    end
  end

  assign step_ext = {{dct_pkg::STEP_W{1'b0}}, step};
  assign mag      = dct_pkg::quarter_mag(step_ext[dct_pkg::STEP_W-1:0]);

  always_comb begin
    if (dc_q) begin
      coef_d = dct_pkg::COEF_W'(DC);
    end else if (neg) begin
      coef_d = -$signed({{(dct_pkg::COEF_W-3){1'b0}}, mag});
    end else begin
      coef_d = $signed({{(dct_pkg::COEF_W-3){1'b0}}, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      twok_q  <= '0;
      dc_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      twok_q  <= twok_d;
      dc_q    <= dc_d;
    end
  end

  // registered alongside the sample buffer read
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      coef_o <= coef_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dct_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dct_mac #(
  parameter int unsigned ACC_W = 28
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire dct_pkg::mac_ctl_t                       ctl_i,
  input  wire logic signed [dct_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire logic signed [dct_pkg::COEF_W-1:0]       coef_i,
  output logic                                         busy_o,
  output logic signed [dct_pkg::COEF_OUT_W-1:0]        result_o
);

  localparam int unsigned PW = dct_pkg::PROD_W;
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(dct_pkg::COEF_MAX);
  localparam logic signed [ACC_W-1:0] MINV = ACC_W'(dct_pkg::COEF_MIN);
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((1 << dct_pkg::FRAC_BITS) - 1);

  logic signed [PW-1:0]    prod_d, prod_q;
  logic                    pvld_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] quot;

  assign prod_d = PW'(sample_i) * PW'(coef_i);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (pvld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign busy_o = pvld_q;

  // divide by 2^FRAC_BITS toward zero: bias negative sums before the shift
  assign biased = acc_q[ACC_W-1] ? acc_q + BIAS : acc_q;
  assign quot   = biased >>> dct_pkg::FRAC_BITS;

  always_comb begin
    if (quot > MAXV) begin
      result_o = dct_pkg::COEF_OUT_W'(MAXV);
    end else if (quot < MINV) begin
      result_o = dct_pkg::COEF_OUT_W'(MINV);
    end else begin
      result_o = dct_pkg::COEF_OUT_W'(quot);
    end
  end

endmodule

`default_nettype wire
